[rtl/wrsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wilder RSI stream package
// Shared widths, constants and the controller state type of the RSI block.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int PRICE_FIELD_W = 32;
    localparam int PERIOD_W      = 8;
    localparam int RSI_W         = 14;
    localparam int OUT_DATA_W    = 16;
    localparam int AVG_W         = 64;
    localparam int PROD_W        = AVG_W + RSI_W;
    localparam int SC_IDX_W      = $clog2(RSI_W);

    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PERIOD_MAX_DEF = 255;

    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 8'd14;
    localparam logic [RSI_W-1:0]    RSI_SCALE    = 14'd10000;
    localparam logic [RSI_W-1:0]    RSI_FULL     = 14'd10000;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PREP = 8'b0000_0010,
        S_DIVP = 8'b0000_0100,
        S_UPD  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_DIVR = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

[rtl/wilder_rsi_stream_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wilder RSI stream
// Streaming relative strength index with Wilder smoothing, bit-serial datapath.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and the block takes the next item as soon
// as the previous result sits in the output register. An item that only stores
// a price or adds to the seed sums passes through the prepare and done states.
// An item that completes the seed or applies smoothing runs the divide-by-period
// unit one quotient bit per cycle, then a bit-serial multiply by 10000 and a
// restoring divide of the product by the sum of the averages. The multiply and
// final divide are skipped when either average is zero.
module wilder_rsi_stream_top #(
    parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = wrsi_pkg::FRAC_BITS_DEF,
    parameter int PERIOD_MAX = wrsi_pkg::PERIOD_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [wrsi_pkg::PRICE_FIELD_W-1:0]  i_s_axis_tdata,  // [31:0] price
    input  logic                                i_s_axis_tuser,  // [0] new_series
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [wrsi_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // [13:0] rsi_hundredths
    output logic                                o_m_axis_tuser,  // [0] rsi_valid
    input  logic                                i_cfg_wr_en,
    input  logic [wrsi_pkg::PERIOD_W-1:0]       i_cfg_wr_data
);
    import wrsi_pkg::*;

    localparam int CNT_W      = $clog2(PERIOD_MAX + 2);
    localparam int CMP_W      = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
    localparam int SEED_ITERS = AVG_W + FRAC_BITS;
    localparam int ITER_W     = $clog2(SEED_ITERS + PROD_W);

    t_state                 r_state, n_state;
    logic [PERIOD_W-1:0]    r_period, n_period;
    logic [PRICE_BITS-1:0]  r_last, n_last;
    logic [PRICE_BITS-1:0]  r_gain, n_gain;
    logic [PRICE_BITS-1:0]  r_loss, n_loss;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [AVG_W-1:0]       r_avg_g, n_avg_g;
    logic [AVG_W-1:0]       r_avg_l, n_avg_l;
    logic [AVG_W-1:0]       r_dq_g, n_dq_g;
    logic [AVG_W-1:0]       r_dq_l, n_dq_l;
    logic [PERIOD_W-1:0]    r_rp_g, n_rp_g;
    logic [PERIOD_W-1:0]    r_rp_l, n_rp_l;
    logic                   r_up_g, n_up_g;
    logic                   r_up_l, n_up_l;
    logic                   r_smooth, n_smooth;
    logic [ITER_W-1:0]      r_iter, n_iter;
    logic [PROD_W-1:0]      r_acc, n_acc;
    logic [AVG_W-1:0]       r_rem, n_rem;
    logic [AVG_W-1:0]       r_s, n_s;
    logic [RSI_W-1:0]       r_q, n_q;
    logic                   r_res_valid, n_res_valid;
    logic                   r_m_valid, n_m_valid;
    logic [RSI_W-1:0]       r_m_data, n_m_data;
    logic                   r_m_user, n_m_user;

    logic [CMP_W-1:0]       w_p;
    logic [PERIOD_W-1:0]    w_p8;
    logic [CMP_W-1:0]       w_n;
    logic [PRICE_BITS-1:0]  w_price;
    logic [AVG_W-1:0]       w_sum_g, w_sum_l;
    logic [AVG_W-1:0]       w_x_g, w_x_l;
    logic                   w_xup_g, w_xup_l;
    logic [AVG_W-1:0]       w_d_g, w_d_l;
    logic                   w_feed;
    logic [PERIOD_W:0]      w_r2_g, w_r2_l;
    logic                   w_ge_g, w_ge_l;
    logic [AVG_W-1:0]       w_rs;
    logic                   w_ge_r;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_m_data);
    assign o_m_axis_tuser  = r_m_user;

    always_comb begin
        w_p = CMP_W'(r_period);
        if (r_period == '0) begin
            w_p = CMP_W'(1);
        end else if (w_p > CMP_W'(PERIOD_MAX)) begin
            w_p = CMP_W'(PERIOD_MAX);
        end
    end

    assign w_p8    = w_p[PERIOD_W-1:0];
    assign w_n     = CMP_W'(r_count);
    assign w_price = PRICE_BITS'(i_s_axis_tdata);

    assign w_sum_g = r_avg_g + AVG_W'(r_gain);
    assign w_sum_l = r_avg_l + AVG_W'(r_loss);
    assign w_x_g   = AVG_W'(r_gain) << FRAC_BITS;
    assign w_x_l   = AVG_W'(r_loss) << FRAC_BITS;
    assign w_xup_g = (w_x_g >= r_avg_g);
    assign w_xup_l = (w_x_l >= r_avg_l);
    assign w_d_g   = w_xup_g ? (w_x_g - r_avg_g)
                             : (r_avg_g - w_x_g + AVG_W'(w_p8) - AVG_W'(1));
    assign w_d_l   = w_xup_l ? (w_x_l - r_avg_l)
                             : (r_avg_l - w_x_l + AVG_W'(w_p8) - AVG_W'(1));

    assign w_feed  = r_smooth || (r_iter >= ITER_W'(FRAC_BITS));
    assign w_r2_g  = {r_rp_g, w_feed & r_dq_g[AVG_W-1]};
    assign w_r2_l  = {r_rp_l, w_feed & r_dq_l[AVG_W-1]};
    assign w_ge_g  = (w_r2_g >= {1'b0, w_p8});
    assign w_ge_l  = (w_r2_l >= {1'b0, w_p8});

    assign w_rs    = {r_rem[AVG_W-2:0], r_acc[PROD_W-1]};
    assign w_ge_r  = (w_rs >= r_s);

    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_last      = r_last;
        n_gain      = r_gain;
        n_loss      = r_loss;
        n_count     = r_count;
        n_avg_g     = r_avg_g;
        n_avg_l     = r_avg_l;
        n_dq_g      = r_dq_g;
        n_dq_l      = r_dq_l;
        n_rp_g      = r_rp_g;
        n_rp_l      = r_rp_l;
        n_up_g      = r_up_g;
        n_up_l      = r_up_l;
        n_smooth    = r_smooth;
        n_iter      = r_iter;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_s         = r_s;
        n_q         = r_q;
        n_res_valid = r_res_valid;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;

        if (i_cfg_wr_en) begin
            n_period = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_last = w_price;
                    n_gain = (w_price >= r_last) ? (w_price - r_last) : '0;
                    n_loss = (w_price < r_last) ? (r_last - w_price) : '0;
                    if (i_s_axis_tuser) begin
                        n_count = '0;
                        n_avg_g = '0;
                        n_avg_l = '0;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_count == '0) begin
                    n_count     = CNT_W'(1);
                    n_res_valid = 1'b0;
                    n_q         = '0;
                    n_state     = S_DONE;
                end else if (w_n <= w_p) begin
                    n_avg_g = w_sum_g;
                    n_avg_l = w_sum_l;
                    n_count = CNT_W'(w_n + CMP_W'(1));
                    if (w_n == w_p) begin
                        n_dq_g   = w_sum_g;
                        n_dq_l   = w_sum_l;
                        n_rp_g   = '0;
                        n_rp_l   = '0;
                        n_smooth = 1'b0;
                        n_iter   = ITER_W'(SEED_ITERS - 1);
                        n_state  = S_DIVP;
                    end else begin
                        n_res_valid = 1'b0;
                        n_q         = '0;
                        n_state     = S_DONE;
                    end
                end else begin
                    n_count  = CNT_W'(w_p + CMP_W'(1));
                    n_dq_g   = w_d_g;
                    n_dq_l   = w_d_l;
                    n_up_g   = w_xup_g;
                    n_up_l   = w_xup_l;
                    n_rp_g   = '0;
                    n_rp_l   = '0;
                    n_smooth = 1'b1;
                    n_iter   = ITER_W'(AVG_W - 1);
                    n_state  = S_DIVP;
                end
            end
            S_DIVP: begin
                n_rp_g = w_ge_g ? PERIOD_W'(w_r2_g - {1'b0, w_p8}) : w_r2_g[PERIOD_W-1:0];
                n_rp_l = w_ge_l ? PERIOD_W'(w_r2_l - {1'b0, w_p8}) : w_r2_l[PERIOD_W-1:0];
                n_dq_g = {r_dq_g[AVG_W-2:0], w_ge_g};
                n_dq_l = {r_dq_l[AVG_W-2:0], w_ge_l};
                if (r_iter == '0) begin
                    n_state = S_UPD;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_UPD: begin
                if (!r_smooth) begin
                    n_avg_g = r_dq_g;
                    n_avg_l = r_dq_l;
                end else begin
                    n_avg_g = r_up_g ? (r_avg_g + r_dq_g) : (r_avg_g - r_dq_g);
                    n_avg_l = r_up_l ? (r_avg_l + r_dq_l) : (r_avg_l - r_dq_l);
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                n_res_valid = 1'b1;
                if (r_avg_l == '0) begin
                    n_q     = RSI_FULL;
                    n_state = S_DONE;
                end else if (r_avg_g == '0) begin
                    n_q     = '0;
                    n_state = S_DONE;
                end else begin
                    n_acc   = '0;
                    n_s     = r_avg_g + r_avg_l;
                    n_iter  = ITER_W'(RSI_W - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = (r_acc << 1)
                      + (RSI_SCALE[r_iter[SC_IDX_W-1:0]] ? PROD_W'(r_avg_g) : '0);
                if (r_iter == '0) begin
                    n_rem   = '0;
                    n_q     = '0;
                    n_iter  = ITER_W'(PROD_W - 1);
                    n_state = S_DIVR;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_DIVR: begin
                n_rem = w_ge_r ? (w_rs - r_s) : w_rs;
                n_q   = {r_q[RSI_W-2:0], w_ge_r};
                n_acc = r_acc << 1;
                if (r_iter == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_q;
                    n_m_user  = r_res_valid;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= RESET_PERIOD;
            r_last    <= '0;
            r_count   <= '0;
            r_avg_g   <= '0;
            r_avg_l   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_period  <= n_period;
            r_last    <= n_last;
            r_count   <= n_count;
            r_avg_g   <= n_avg_g;
            r_avg_l   <= n_avg_l;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain      <= n_gain;
        r_loss      <= n_loss;
        r_dq_g      <= n_dq_g;
        r_dq_l      <= n_dq_l;
        r_rp_g      <= n_rp_g;
        r_rp_l      <= n_rp_l;
        r_up_g      <= n_up_g;
        r_up_l      <= n_up_l;
        r_smooth    <= n_smooth;
        r_iter      <= n_iter;
        r_acc       <= n_acc;
        r_rem       <= n_rem;
        r_s         <= n_s;
        r_q         <= n_q;
        r_res_valid <= n_res_valid;
        r_m_data    <= n_m_data;
        r_m_user    <= n_m_user;
    end

endmodule
